// ===== rtl/core/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared entry type, request codes, status codes and the command that the
// queue controller broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Request kinds carried on the func field.
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_PEEK   = 2'd2;

    // Status codes returned with every result.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Width of the occupancy field.
    localparam int OCC_W = 5;

    // One stored entry: data word and its priority.
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } entry_t;

    // Command broadcast to all cells in the cycle a request is taken.
    typedef struct packed {
        logic   insert_en;
        logic   remove_en;
        entry_t new_entry;
    } cell_cmd_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry of the sorted chain. On insert it compares its priority
// with the new one and either keeps its entry, takes the new entry, or takes
// its left neighbor's entry. On remove it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               aclk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_move,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               move
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // The entry moves right when the cell is empty or the new item goes ahead
    // of it. Equal priorities keep the older entry in front.
    assign move = !occupied || ($signed(entry_reg.prio) > $signed(cmd.new_entry.prio));

    // Pick the next content of this cell.
    always_comb begin
        entry_next = entry_reg;
        if (cmd.insert_en && move) begin
            entry_next = left_move ? left_entry : cmd.new_entry;
        end else if (cmd.remove_en) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/sorted_priority_queue_top.sv =====
// A result is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle while m_ready stays high; every cell
// does its compare and shift in the same cycle.
// Reset clears the entry count and the result valid; stored entries are
// undefined until written and are never read beyond the entry count.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue top level
// A chain of compare-and-shift cells keeps entries sorted by priority,
// smallest first, oldest first among equal priorities. Remove and peek return
// the removed or head entry; each result has a status and the new occupancy.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
    parameter int CAPACITY = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic signed [31:0] s_item_value,
    input  logic signed [31:0] s_item_priority,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_value,
    output logic signed [31:0] m_out_priority,
    output logic [1:0]         m_status,
    output logic [4:0]         m_occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic signed [31:0]         m_value_reg;
    logic signed [31:0]         m_value_next;
    logic signed [31:0]         m_prio_reg;
    logic signed [31:0]         m_prio_next;
    logic [1:0]                 m_status_reg;
    logic [1:0]                 m_status_next;
    logic [spq_pkg::OCC_W-1:0]  m_occ_reg;
    logic [spq_pkg::OCC_W-1:0]  m_occ_next;

    logic                       accept;
    logic                       is_empty;
    logic                       is_full;
    spq_pkg::cell_cmd_t         cmd;
    spq_pkg::entry_t            cell_entry [CAPACITY];
    logic                       cell_move  [CAPACITY];

    // The output register is free when it is empty or its result is being taken.
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CAP_COUNT);

    // Decode the request into a command for the chain.
    always_comb begin
        cmd.insert_en       = accept && (s_func == spq_pkg::FUNC_INSERT) && !is_full;
        cmd.remove_en       = accept && (s_func == spq_pkg::FUNC_REMOVE) && !is_empty;
        cmd.new_entry.value = s_item_value;
        cmd.new_entry.prio  = s_item_priority;
    end

    // The chain of cells, one entry each.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        spq_pkg::entry_t left_entry;
        logic            left_move;
        spq_pkg::entry_t right_entry;

        if (i == 0) begin : g_first
            assign left_entry = '0;
            assign left_move  = 1'b0;
        end else begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign left_move  = cell_move[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .occupied    (CW'(i) < count_reg),
            .left_entry  (left_entry),
            .left_move   (left_move),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .move        (cell_move[i])
        );
    end

    // Count and result for the accepted request.
    always_comb begin
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        m_value_next  = m_value_reg;
        m_prio_next   = m_prio_reg;
        m_status_next = m_status_reg;
        m_occ_next    = m_occ_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            m_valid_next  = 1'b1;
            m_value_next  = '0;
            m_prio_next   = '0;
            m_status_next = spq_pkg::STATUS_OK;
            case (s_func)
                spq_pkg::FUNC_INSERT: begin
                    if (is_full) begin
                        m_status_next = spq_pkg::STATUS_FULL;
                    end else begin
                        count_next = count_reg + CW'(1);
                    end
                end
                spq_pkg::FUNC_REMOVE: begin
                    if (is_empty) begin
                        m_status_next = spq_pkg::STATUS_EMPTY;
                    end else begin
                        m_value_next = cell_entry[0].value;
                        m_prio_next  = cell_entry[0].prio;
                        count_next   = count_reg - CW'(1);
                    end
                end
                default: begin
                    // Peek; the unused code also reads the head.
                    if (is_empty) begin
                        m_status_next = spq_pkg::STATUS_EMPTY;
                    end else begin
                        m_value_next = cell_entry[0].value;
                        m_prio_next  = cell_entry[0].prio;
                    end
                end
            endcase
            m_occ_next = spq_pkg::OCC_W'(count_next);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        m_value_reg  <= m_value_next;
        m_prio_reg   <= m_prio_next;
        m_status_reg <= m_status_next;
        m_occ_reg    <= m_occ_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_value    = m_value_reg;
    assign m_out_priority = m_prio_reg;
    assign m_status       = m_status_reg;
    assign m_occupancy    = m_occ_reg;

endmodule
